// ----- design/rtpf_pkg.sv -----
package rtpf_pkg;

  // Sieve size and derived widths
  localparam int MAX_LIMIT = 32767;
  localparam int BM_DEPTH  = MAX_LIMIT + 1;
  localparam int BM_AW     = $clog2(BM_DEPTH);

  // Fixed field widths
  localparam int LIM_W = 15;
  localparam int NUM_W = 32;
  localparam int CNT_W = 16;

  // Sieve candidate counter: the last candidate tried satisfies p*p > bound
  localparam int P_W   = BM_AW / 2 + 1;

  // Shared multiplier operand width and divide-by-ten reciprocal
  localparam int                MUL_W       = 16;
  localparam logic [MUL_W-1:0] RECIP_10    = 16'd52429;
  localparam int                RECIP_SHIFT = 19;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes
  localparam int               CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd1;
  localparam logic [LIM_W-1:0] HIGH_LIMIT_RST = 15'd32767;

  // Bitmap access request
  typedef struct packed {
    logic             we;
    logic             wdata;
    logic [BM_AW-1:0] waddr;
    logic [BM_AW-1:0] raddr;
  } bm_req_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    logic match;
  } res_t;

endpackage

// ----- design/rtpf_bitmap.sv -----
module rtpf_bitmap (
  input  logic              clk,
  input  rtpf_pkg::bm_req_t req,
  output logic              rd_bit
);
  import rtpf_pkg::*;

  logic mem_r [BM_DEPTH];
  logic rd_bit_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rd_bit_r <= mem_r[req.raddr];
  end

  assign rd_bit = rd_bit_r;

endmodule

// ----- design/rtpf_ctrl.sv -----
module rtpf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rtpf_pkg::LIM_W-1:0]  low_limit,
  input  logic [rtpf_pkg::LIM_W-1:0]  high_limit,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rtpf_pkg::NUM_W-1:0]  in_number,
  input  logic                        out_free,
  output rtpf_pkg::res_t              res,
  output logic [rtpf_pkg::NUM_W-1:0]  value,
  output rtpf_pkg::bm_req_t           bm_req,
  input  logic                        bm_rd_bit
);
  import rtpf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_P_MUL,
    S_P_TEST,
    S_P_CHK,
    S_MARK,
    S_P_NEXT,
    S_Q_START,
    S_Q_READ,
    S_Q_CHK,
    S_DONE
  } state_t;

  state_t               state_r;
  logic                 sieve_ready_r;
  logic [NUM_W-1:0]     value_r;
  logic [BM_AW-1:0]     addr_r;
  logic [P_W-1:0]       p_r;
  logic [2*MUL_W-1:0]   prod_r;
  logic                 match_r;

  logic [BM_AW-1:0]     bound;
  logic [BM_AW:0]       add_a;
  logic [BM_AW:0]       add_b;
  logic [BM_AW:0]       sum;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   product;
  logic [BM_AW-1:0]     quot;
  logic                 in_range;

  // Sieve bound is the high limit capped at the bitmap size
  assign bound = (NUM_W'(high_limit) > NUM_W'(MAX_LIMIT)) ? BM_AW'(MAX_LIMIT)
                                                          : BM_AW'(high_limit);

  assign in_range = (value_r >= NUM_W'(low_limit)) && (value_r <= NUM_W'(high_limit)) &&
                    (value_r <= NUM_W'(MAX_LIMIT));

  // Shared adder: clear address step, multiple step, prime step
  always_comb begin
    case (state_r)
      S_CLEAR: begin
        add_a = {1'b0, addr_r};
        add_b = (BM_AW+1)'(1);
      end
      S_MARK: begin
        add_a = {1'b0, addr_r};
        add_b = (BM_AW+1)'(p_r);
      end
      S_P_NEXT: begin
        add_a = (BM_AW+1)'(p_r);
        add_b = (BM_AW+1)'(1);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign sum = add_a + add_b;

  // Shared multiplier: p squared, or divide by ten through the reciprocal
  always_comb begin
    case (state_r)
      S_P_MUL: begin
        mul_a = MUL_W'(p_r);
        mul_b = MUL_W'(p_r);
      end
      S_Q_READ: begin
        mul_a = MUL_W'(addr_r);
        mul_b = RECIP_10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign product = mul_a * mul_b;
  assign quot    = BM_AW'(prod_r >> RECIP_SHIFT);

  // Bitmap port: clear and mark write, prime test and query read
  always_comb begin
    bm_req.we    = (state_r == S_CLEAR) || (state_r == S_MARK);
    bm_req.wdata = (state_r == S_CLEAR) ? (addr_r < BM_AW'(2)) : 1'b1;
    bm_req.waddr = addr_r;
    bm_req.raddr = (state_r == S_P_TEST) ? BM_AW'(p_r) : addr_r;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res.valid = (state_r == S_DONE) && out_free;
  assign res.match = match_r;
  assign value     = value_r;

  // Sequencer state and bitmap-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sieve_ready_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sieve_ready_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= sieve_ready_r ? S_Q_START : S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (addr_r == bound) begin
            state_r <= S_P_MUL;
          end
        end
        S_P_MUL: state_r <= S_P_TEST;
        S_P_TEST: begin
          if (prod_r > (2*MUL_W)'(bound)) begin
            sieve_ready_r <= 1'b1;
            state_r       <= S_Q_START;
          end else begin
            state_r <= S_P_CHK;
          end
        end
        S_P_CHK: state_r <= bm_rd_bit ? S_P_NEXT : S_MARK;
        S_MARK: begin
          if (sum > (BM_AW+1)'(bound)) begin
            state_r <= S_P_NEXT;
          end
        end
        S_P_NEXT:  state_r <= S_P_MUL;
        S_Q_START: state_r <= in_range ? S_Q_READ : S_DONE;
        S_Q_READ:  state_r <= S_Q_CHK;
        S_Q_CHK: begin
          if (bm_rd_bit || (quot == '0)) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_Q_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        value_r <= in_number;
        addr_r  <= '0;
      end
      S_CLEAR: begin
        addr_r <= sum[BM_AW-1:0];
        p_r    <= P_W'(2);
      end
      S_P_MUL: prod_r <= product;
      S_P_CHK: addr_r <= prod_r[BM_AW-1:0];
      S_MARK:  addr_r <= sum[BM_AW-1:0];
      S_P_NEXT: p_r   <= sum[P_W-1:0];
      S_Q_START: begin
        addr_r  <= value_r[BM_AW-1:0];
        match_r <= 1'b0;
      end
      S_Q_READ: prod_r <= product;
      S_Q_CHK: begin
        addr_r  <= quot;
        match_r <= !bm_rd_bit && (quot == '0);
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer ready right after a transfer");

  a_result_needs_sieve: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> sieve_ready_r)
    else $error("result issued without a built bitmap");

  a_mark_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (addr_r <= bound))
    else $error("sieve marks past the bound");

  a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_CHK) |-> ($past(state_r) == S_Q_READ))
    else $error("prefix check without a bitmap read");

endmodule

// ----- design/right_truncatable_prime_filter_top.sv -----
// Right-truncatable prime filter.
// Input channel (in_valid/in_ready) takes one 32-bit number per transfer.
// Output channel (out_valid/out_ready) returns one result per number: the
// match flag, the number itself and the saturating count of matches.
// Configuration: cfg_we with cfg_index 0 (low limit) or 1 (high limit);
// any write forces a new sieve build before the next number.
// Sieve build (first number after reset or a write): a clearing pass over
// the bitmap, then for each candidate prime p with p*p <= bound a bitmap
// test and, if p is unmarked, one write per multiple marked. The single
// bitmap write port sets the build time.
// Query: one bitmap read and one shared multiply for the divide by ten per
// decimal prefix looked up; one number is worked on at a time.
// The output register holds a finished result while the receiver stalls;
// the next number is taken meanwhile, and its result waits for the slot.
// Reset (synchronous, rst_n low) restores the limits to 0 and 32767, marks
// the bitmap stale and clears the match count.
module right_truncatable_prime_filter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rtpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpf_pkg::LIM_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rtpf_pkg::NUM_W-1:0]      in_number_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_is_match,
  output logic [rtpf_pkg::NUM_W-1:0]      out_echoed_value,
  output logic [rtpf_pkg::CNT_W-1:0]      out_match_count
);
  import rtpf_pkg::*;

  logic [LIM_W-1:0] low_limit_r;
  logic [LIM_W-1:0] high_limit_r;
  logic             out_valid_r;
  logic             out_is_match_r;
  logic [NUM_W-1:0] out_echoed_r;
  logic [CNT_W-1:0] count_r;
  logic             out_free;
  res_t             res;
  logic [NUM_W-1:0] value;
  bm_req_t          bm_req;
  logic             bm_rd_bit;

  assign out_free = !out_valid_r || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= '0;
      high_limit_r <= HIGH_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_LIMIT:  low_limit_r  <= cfg_data;
        CFG_HIGH_LIMIT: high_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register and running match count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
      if (res.match && (count_r != CNT_MAX)) begin
        count_r <= count_r + CNT_W'(1);
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold result payload until the transfer
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_is_match_r <= res.match;
      out_echoed_r   <= value;
    end
  end

  rtpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .low_limit  (low_limit_r),
    .high_limit (high_limit_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_number  (in_number_value),
    .out_free   (out_free),
    .res        (res),
    .value      (value),
    .bm_req     (bm_req),
    .bm_rd_bit  (bm_rd_bit)
  );

  rtpf_bitmap u_bitmap (
    .clk    (clk),
    .req    (bm_req),
    .rd_bit (bm_rd_bit)
  );

  assign out_valid        = out_valid_r;
  assign out_is_match     = out_is_match_r;
  assign out_echoed_value = out_echoed_r;
  assign out_match_count  = count_r;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rtpf_pkg::*;

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_B = 2'd3;

  typedef struct {
    bit               is_match;
    logic [NUM_W-1:0] value;
    logic [CNT_W-1:0] count;
  } verdict_t;

  typedef struct {
    logic [NUM_W-1:0] value;
    bit               known;
    bit               want_match;
  } probe_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIM_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [NUM_W-1:0]     in_number_value;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_is_match;
  logic [NUM_W-1:0]     out_echoed_value;
  logic [CNT_W-1:0]     out_match_count;

  // Shadow state of the filter
  bit               composite [0:MAX_LIMIT];
  bit               sieve_stale = 1'b1;
  logic [LIM_W-1:0] lo_lim = '0;
  logic [LIM_W-1:0] hi_lim = HIGH_LIMIT_RST;
  logic [CNT_W-1:0] match_total = '0;

  verdict_t    expected_verdicts [$];
  int unsigned truncatable_primes [$];
  int unsigned error_count = 0;
  bit          quiet = 1'b0;

  // Hand-picked numbers; known rows carry the answer under default limits
  probe_row_t probe_rows [25] = '{
    '{32'd0,            1'b1, 1'b0},
    '{32'd1,            1'b1, 1'b0},
    '{32'd2,            1'b1, 1'b1},
    '{32'd3,            1'b1, 1'b1},
    '{32'd5,            1'b1, 1'b1},
    '{32'd7,            1'b1, 1'b1},
    '{32'd4,            1'b1, 1'b0},
    '{32'd9,            1'b1, 1'b0},
    '{32'd11,           1'b1, 1'b0},
    '{32'd19,           1'b1, 1'b0},
    '{32'd21,           1'b1, 1'b0},
    '{32'd23,           1'b1, 1'b1},
    '{32'd29,           1'b1, 1'b1},
    '{32'd2333,         1'b1, 1'b1},
    '{32'd23333,        1'b1, 1'b1},
    '{32'd31193,        1'b1, 1'b1},
    '{32'd29399,        1'b1, 1'b1},
    '{32'd32767,        1'b1, 1'b0},
    '{32'd32768,        1'b1, 1'b0},
    '{32'd37337,        1'b1, 1'b0},
    '{32'd73939133,     1'b1, 1'b0},
    '{32'hFFFF_FFFF,    1'b1, 1'b0},
    '{32'h8000_0000,    1'b1, 1'b0},
    '{32'd31379,        1'b0, 1'b0},
    '{32'd10007,        1'b0, 1'b0}
  };

  right_truncatable_prime_filter_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number_value  (in_number_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_match     (out_is_match),
    .out_echoed_value (out_echoed_value),
    .out_match_count  (out_match_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #32_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Decide whether a number is an in-range right-truncatable prime
  function automatic bit judge_number(logic [NUM_W-1:0] v);
    int unsigned bound;
    int unsigned p;
    int unsigned m;
    int unsigned t;
    if (sieve_stale) begin
      bound = (hi_lim < MAX_LIMIT) ? hi_lim : MAX_LIMIT;
      foreach (composite[i]) composite[i] = 1'b0;
      composite[0] = 1'b1;
      composite[1] = 1'b1;
      for (p = 2; p * p <= bound; p++) begin
        if (!composite[p]) begin
          for (m = p * p; m <= bound; m += p) composite[m] = 1'b1;
        end
      end
      sieve_stale = 1'b0;
    end
    if (v < lo_lim || v > hi_lim || v > MAX_LIMIT) return 1'b0;
    t = v;
    do begin
      if (t > MAX_LIMIT || composite[t]) return 1'b0;
      t = t / 10;
    end while (t != 0);
    return 1'b1;
  endfunction

  // Draw a number weighted toward truncatable primes and limit edges
  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned r;
    int unsigned c;
    r = $urandom_range(99);
    if (r < 45) begin
      c = truncatable_primes[$urandom_range(truncatable_primes.size() - 1)];
      for (int k = 0; k < 8 && (c < lo_lim || c > hi_lim); k++)
        c = truncatable_primes[$urandom_range(truncatable_primes.size() - 1)];
      return c;
    end
    if (r < 57)
      return truncatable_primes[$urandom_range(truncatable_primes.size() - 1)] * 10
             + $urandom_range(9);
    if (r < 77) begin
      if (lo_lim <= hi_lim) return $urandom_range(hi_lim, lo_lim);
      return $urandom_range(MAX_LIMIT);
    end
    if (r < 89) begin
      case ($urandom_range(7))
        0: return lo_lim;
        1: return hi_lim;
        2: return {17'd0, lo_lim} - 32'd1;
        3: return {17'd0, hi_lim} + 32'd1;
        4: return 32'd0;
        5: return 32'd1;
        6: return MAX_LIMIT;
        default: return MAX_LIMIT + 1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Present one number, hold it until the transfer, then log its verdict
  task automatic offer_number(logic [NUM_W-1:0] v, bit known, bit want);
    verdict_t e;
    bit       m;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_number_value <= v;
    do @(posedge clk); while (!in_ready);
    m = known ? want : judge_number(v);
    if (m && match_total != CNT_MAX) match_total++;
    e.is_match = m;
    e.value    = v;
    e.count    = match_total;
    expected_verdicts.push_back(e);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOW_LIMIT: begin
        lo_lim      = data;
        sieve_stale = 1'b1;
      end
      CFG_HIGH_LIMIT: begin
        hi_lim      = data;
        sieve_stale = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Drop valid, wait for every verdict, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_random(int items, bit with_calm);
    for (int i = 0; i < items; i++) begin
      quiet = with_calm && i >= items / 3 && i < 2 * items / 3;
      offer_number(pick_number(), 1'b0, 1'b0);
    end
    quiet = 1'b0;
  endtask

  // Result sink: random back-pressure
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= quiet || ($urandom_range(99) >= 32);
    end
  end

  // Compare each result transfer against the oldest verdict
  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, value %0d", out_echoed_value));
      end else begin
        w = expected_verdicts.pop_front();
        if (out_is_match !== w.is_match)
          report_mismatch($sformatf("value %0d: is_match %b, want %b",
                                    w.value, out_is_match, w.is_match));
        if (out_echoed_value !== w.value)
          report_mismatch($sformatf("echoed_value %0d, want %0d",
                                    out_echoed_value, w.value));
        if (out_match_count !== w.count)
          report_mismatch($sformatf("value %0d: match_count %0d, want %0d",
                                    w.value, out_match_count, w.count));
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned q;
    int unsigned d;
    bit          prime;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_LOW_LIMIT;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_number_value <= '0;
    rst_n           <= 1'b0;

    // Grow the truncatable primes digit by digit up to the sieve size
    truncatable_primes = '{2, 3, 5, 7};
    for (int i = 0; i < truncatable_primes.size(); i++) begin
      for (d = 1; d <= 9; d += 2) begin
        n = truncatable_primes[i] * 10 + d;
        if (d != 5 && n <= MAX_LIMIT) begin
          prime = 1'b1;
          for (q = 2; q * q <= n; q++) if (n % q == 0) prime = 1'b0;
          if (prime) truncatable_primes.push_back(n);
        end
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Default limits straight after reset
    foreach (probe_rows[i])
      offer_number(probe_rows[i].value, probe_rows[i].known, probe_rows[i].want_match);
    run_random(400, 1'b1);

    settle();
    write_reg(CFG_LOW_LIMIT, 15'd100);
    write_reg(CFG_HIGH_LIMIT, 15'd5000);
    run_random(350, 1'b0);

    // Inverted limits, plus writes to unused indexes
    settle();
    write_reg(CFG_LOW_LIMIT, 15'd32767);
    write_reg(CFG_HIGH_LIMIT, 15'd0);
    write_reg(CFG_NO_REG_A, LIM_W'($urandom_range(32767)));
    write_reg(CFG_NO_REG_B, LIM_W'($urandom_range(32767)));
    run_random(150, 1'b0);

    settle();
    write_reg(CFG_LOW_LIMIT, 15'd0);
    write_reg(CFG_HIGH_LIMIT, 15'd1000);
    run_random(300, 1'b0);

    settle();
    write_reg(CFG_LOW_LIMIT, 15'd2000);
    write_reg(CFG_HIGH_LIMIT, 15'd32767);
    run_random(350, 1'b1);

    // Single-value window
    settle();
    write_reg(CFG_LOW_LIMIT, 15'd23);
    write_reg(CFG_HIGH_LIMIT, 15'd23);
    run_random(150, 1'b0);

    settle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rtpf_pkg.sv
design/rtpf_bitmap.sv
design/rtpf_ctrl.sv
design/right_truncatable_prime_filter_top.sv
test/testbench.sv
